### hw/rtl/pcma_pkg.sv
package pcma_pkg;

    localparam int SLOTS_PER_BANK_DEF = 8;

    localparam int CMD_W   = 2;
    localparam int PIN_W   = 8;
    localparam int TIMER_W = 3;
    localparam int CHAN_W  = 3;

    localparam logic [PIN_W-1:0]   EMPTY_PIN     = 8'hFF;
    localparam logic [TIMER_W-1:0] HS_LAST_TIMER = 3'd3;

    localparam logic [CMD_W-1:0] CMD_LOOKUP   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;

    // request as seen by every cell during the scan cycle
    typedef struct packed {
        logic             active;
        logic [CMD_W-1:0] command;
        logic [PIN_W-1:0] pin;
        logic             bank;
    } req_t;

    // priority flags rippled from cell to cell
    typedef struct packed {
        logic hit;
        logic free;
    } chain_t;

endpackage

### hw/rtl/pcma_ifs.sv
interface pcma_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [pcma_pkg::CMD_W-1:0]    command;
    logic [pcma_pkg::PIN_W-1:0]    pin;
    logic [pcma_pkg::TIMER_W-1:0]  timer_id;

    modport source (output valid, output command, output pin, output timer_id, input ready);
    modport sink (input valid, input command, input pin, input timer_id, output ready);
endinterface

interface pcma_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [pcma_pkg::CHAN_W-1:0] channel;
    logic                        allocated;

    modport source (output valid, output found, output channel, output allocated, input ready);
    modport sink (input valid, input found, input channel, input allocated, output ready);
endinterface

### hw/rtl/pcma_cell.sv
module pcma_cell #(
    parameter int IDX_W = 3,
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  pcma_pkg::req_t       req,
    input  logic                 any_hit,
    input  pcma_pkg::chain_t     chain_in,
    input  logic [IDX_W-1:0]     hit_idx_in,
    input  logic [IDX_W-1:0]     free_idx_in,
    output pcma_pkg::chain_t     chain_out,
    output logic [IDX_W-1:0]     hit_idx_out,
    output logic [IDX_W-1:0]     free_idx_out
);

    // one slot of each bank: index 0 high-speed, index 1 low-speed
    logic [1:0][pcma_pkg::PIN_W-1:0] slot_reg;
    logic [1:0][pcma_pkg::PIN_W-1:0] slot_next;

    logic [pcma_pkg::PIN_W-1:0] cur;
    logic match;
    logic empty;
    logic first_hit;
    logic first_free;

    always_comb
    begin
        cur        = slot_reg[req.bank];
        match      = req.active && (cur == req.pin);
        empty      = (cur == pcma_pkg::EMPTY_PIN);
        first_hit  = match && !chain_in.hit;
        first_free = empty && !chain_in.free;

        chain_out.hit  = chain_in.hit | match;
        chain_out.free = chain_in.free | empty;
        hit_idx_out    = first_hit ? IDX_W'(INDEX) : hit_idx_in;
        free_idx_out   = first_free ? IDX_W'(INDEX) : free_idx_in;
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (fire && req.active)
        begin
            if (req.command == pcma_pkg::CMD_RELEASE && first_hit)
            begin
                slot_next[req.bank] = pcma_pkg::EMPTY_PIN;
            end
            else if (req.command == pcma_pkg::CMD_ALLOCATE && !any_hit && first_free)
            begin
                slot_next[req.bank] = req.pin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= {2{pcma_pkg::EMPTY_PIN}};
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

### hw/rtl/pin_channel_map_allocator.sv
// pin-to-channel slot map, two banks of SLOTS_PER_BANK slots each
// cmd channel: one transaction carries command, pin and timer_id; a timer
// above 3 picks the low-speed bank, 0 to 3 the high-speed bank
// rsp channel: one transaction per command with found, channel, allocated
// a command accepted into the request register is scanned once the output
// register is free or being emptied, and its response is registered there;
// the scan is a single pass down the row of slot cells, each cell holding
// one slot of both banks and rippling first-hit / first-free flags
// a new command is taken only after the previous one has been scanned
// the response sits in an output register; while the receiver stalls, one
// more command is accepted and held until that register frees up
// reset: every slot reads empty at once, no clearing pass is needed
// pin 255 and command code 3 answer not found and change nothing
module pin_channel_map_allocator #(
    parameter int SLOTS_PER_BANK = pcma_pkg::SLOTS_PER_BANK_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pcma_cmd_if.sink     cmd,
    pcma_rsp_if.source   rsp
);

    localparam int IDX_W = (SLOTS_PER_BANK > 1) ? $clog2(SLOTS_PER_BANK) : 1;

    pcma_pkg::req_t req_reg;
    pcma_pkg::req_t req_next;
    logic           req_valid_reg;
    logic           req_valid_next;

    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    logic                        found_reg;
    logic                        found_next;
    logic [pcma_pkg::CHAN_W-1:0] channel_reg;
    logic [pcma_pkg::CHAN_W-1:0] channel_next;
    logic                        allocated_reg;
    logic                        allocated_next;

    logic accept;
    logic fire;
    logic any_hit;
    logic any_free;
    logic do_alloc;

    pcma_pkg::chain_t chain [SLOTS_PER_BANK+1];
    logic [IDX_W-1:0] hit_idx [SLOTS_PER_BANK+1];
    logic [IDX_W-1:0] free_idx [SLOTS_PER_BANK+1];

    assign chain[0]    = '0;
    assign hit_idx[0]  = '0;
    assign free_idx[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS_PER_BANK; gi++)
        begin : g_cell
            pcma_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .fire         (fire),
                .req          (req_reg),
                .any_hit      (any_hit),
                .chain_in     (chain[gi]),
                .hit_idx_in   (hit_idx[gi]),
                .free_idx_in  (free_idx[gi]),
                .chain_out    (chain[gi+1]),
                .hit_idx_out  (hit_idx[gi+1]),
                .free_idx_out (free_idx[gi+1])
            );
        end
    endgenerate

    assign cmd.ready = !req_valid_reg;
    assign accept    = cmd.valid && !req_valid_reg;
    assign fire      = req_valid_reg && (!rsp_valid_reg || rsp.ready);

    assign any_hit  = chain[SLOTS_PER_BANK].hit;
    assign any_free = chain[SLOTS_PER_BANK].free;
    assign do_alloc = req_reg.active && (req_reg.command == pcma_pkg::CMD_ALLOCATE)
                      && !any_hit && any_free;

    always_comb
    begin
        req_next       = req_reg;
        req_valid_next = req_valid_reg;
        if (fire)
        begin
            req_valid_next = 1'b0;
        end
        if (accept)
        begin
            req_valid_next   = 1'b1;
            req_next.command = cmd.command;
            req_next.pin     = cmd.pin;
            req_next.bank    = (cmd.timer_id > pcma_pkg::HS_LAST_TIMER);
            req_next.active  = (cmd.pin != pcma_pkg::EMPTY_PIN)
                               && (cmd.command inside {pcma_pkg::CMD_LOOKUP,
                                                       pcma_pkg::CMD_ALLOCATE,
                                                       pcma_pkg::CMD_RELEASE});
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        found_next     = found_reg;
        channel_next   = channel_reg;
        allocated_next = allocated_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            rsp_valid_next = 1'b1;
            allocated_next = do_alloc;
            if (req_reg.active && any_hit)
            begin
                found_next   = 1'b1;
                channel_next = pcma_pkg::CHAN_W'(hit_idx[SLOTS_PER_BANK]);
            end
            else if (do_alloc)
            begin
                found_next   = 1'b1;
                channel_next = pcma_pkg::CHAN_W'(free_idx[SLOTS_PER_BANK]);
            end
            else
            begin
                found_next   = 1'b0;
                channel_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        found_reg     <= found_next;
        channel_reg   <= channel_next;
        allocated_reg <= allocated_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.found     = found_reg;
    assign rsp.channel   = channel_reg;
    assign rsp.allocated = allocated_reg;

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = pcma_pkg::SLOTS_PER_BANK_DEF;
    localparam logic [pcma_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1350;
    localparam int POOL_SIZE = 10;

    typedef struct packed {
        logic [pcma_pkg::CMD_W-1:0]   command;
        logic [pcma_pkg::PIN_W-1:0]   pin;
        logic [pcma_pkg::TIMER_W-1:0] timer_id;
    } map_cmd_t;

    typedef struct packed {
        logic                        found;
        logic [pcma_pkg::CHAN_W-1:0] channel;
        logic                        allocated;
    } map_result_t;

    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE} ready_mode_t;

    class slot_map_scoreboard;
        logic [pcma_pkg::PIN_W-1:0] slot_pin [2*SLOTS];
        map_result_t                pending_results [$];
        int                         errors;

        function new();
            foreach (slot_pin[i])
                slot_pin[i] = pcma_pkg::EMPTY_PIN;
            errors = 0;
        endfunction

        // first-hit / first-free scan over the selected bank
        function void predict_command(map_cmd_t c);
            map_result_t r;
            int          base;
            int          hit;
            int          free_slot;
            r = '0;
            base = (c.timer_id > pcma_pkg::HS_LAST_TIMER) ? SLOTS : 0;
            hit = -1;
            free_slot = -1;
            if (c.pin != pcma_pkg::EMPTY_PIN && c.command != CMD_UNUSED)
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (slot_pin[base+i] == c.pin)
                        hit = i;
                    if (slot_pin[base+i] == pcma_pkg::EMPTY_PIN)
                        free_slot = i;
                end
                if (c.command == pcma_pkg::CMD_ALLOCATE && hit < 0)
                begin
                    if (free_slot >= 0)
                    begin
                        slot_pin[base+free_slot] = c.pin;
                        hit = free_slot;
                        r.allocated = 1'b1;
                    end
                end
                else if (c.command == pcma_pkg::CMD_RELEASE && hit >= 0)
                begin
                    slot_pin[base+hit] = pcma_pkg::EMPTY_PIN;
                end
                if (hit >= 0)
                begin
                    r.found = 1'b1;
                    r.channel = hit[pcma_pkg::CHAN_W-1:0];
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_response(map_result_t got);
            map_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("response with no command outstanding: found=%0d channel=%0d allocated=%0d",
                       got.found, got.channel, got.allocated);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.channel !== want.channel)
            begin
                $error("channel: expected %0d, got %0d", want.channel, got.channel);
                errors++;
            end
            if (got.allocated !== want.allocated)
            begin
                $error("allocated: expected %0d, got %0d", want.allocated, got.allocated);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pcma_cmd_if cmd_bus ();
    pcma_rsp_if rsp_bus ();

    slot_map_scoreboard board = new();

    map_cmd_t                   stimulus [$];
    logic [pcma_pkg::PIN_W-1:0] pin_pool [POOL_SIZE];

    pin_channel_map_allocator #(
        .SLOTS_PER_BANK(SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[pin_channel_map_allocator] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            board.check_response('{rsp_bus.found, rsp_bus.channel, rsp_bus.allocated});
    end

    function automatic map_cmd_t make_cmd(logic [pcma_pkg::CMD_W-1:0] command,
                                          logic [pcma_pkg::PIN_W-1:0] pin,
                                          logic [pcma_pkg::TIMER_W-1:0] timer_id);
        map_cmd_t c;
        c.command = command;
        c.pin = pin;
        c.timer_id = timer_id;
        return c;
    endfunction

    // mostly pins from a small pool so banks fill up and hits are common
    function automatic map_cmd_t random_cmd(bit release_heavy);
        map_cmd_t c;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            c.command = CMD_UNUSED;
        else if (roll < 28)
            c.command = pcma_pkg::CMD_LOOKUP;
        else if (roll < (release_heavy ? 72 : 45))
            c.command = pcma_pkg::CMD_RELEASE;
        else
            c.command = pcma_pkg::CMD_ALLOCATE;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            c.pin = pcma_pkg::EMPTY_PIN;
        else if (roll < 13)
            c.pin = pcma_pkg::PIN_W'($urandom_range(0, 255));
        else
            c.pin = pin_pool[$urandom_range(0, POOL_SIZE - 1)];
        c.timer_id = pcma_pkg::TIMER_W'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic drive_command(map_cmd_t c);
        @(negedge clk);
        cmd_bus.valid <= 1'b1;
        cmd_bus.command <= c.command;
        cmd_bus.pin <= c.pin;
        cmd_bus.timer_id <= c.timer_id;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        board.predict_command(c);
    endtask

    task automatic idle_sender(int cycles);
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // receiver: random stall modes, plus long hold-offs to back up the input
    initial
    begin
        int          cycle;
        int          hold;
        int          mode_left;
        ready_mode_t mode;
        cycle = 0;
        hold = 0;
        mode_left = 0;
        mode = RDY_ALWAYS;
        rsp_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cycle++;
            if (cycle == 1200 || cycle == 3000)
                hold = 300;
            if (hold > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = ready_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RDY_ALWAYS: rsp_bus.ready <= 1'b1;
                    RDY_HALF:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                    default:    rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int burst_left;
        rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.command = pcma_pkg::CMD_LOOKUP;
        cmd_bus.pin = '0;
        cmd_bus.timer_id = '0;

        pin_pool[0] = 8'd0;
        pin_pool[1] = 8'd254;
        for (int i = 2; i < POOL_SIZE; i++)
            pin_pool[i] = pcma_pkg::PIN_W'($urandom_range(0, 254));

        // directed part
        stimulus.push_back(make_cmd(pcma_pkg::CMD_LOOKUP, 8'd0, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, 8'd0, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, 8'd254, 3'd7));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_LOOKUP, 8'd254, 3'd4));
        // timer 3 is still the high-speed bank
        stimulus.push_back(make_cmd(pcma_pkg::CMD_LOOKUP, 8'd254, 3'd3));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, 8'd0, 3'd3));
        for (int p = 1; p < SLOTS; p++)
            stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE,
                                        p[pcma_pkg::PIN_W-1:0], 3'd1));
        // bank full
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, 8'd100, 3'd2));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_RELEASE, 8'd50, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_RELEASE, 8'd3, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, 8'd100, 3'd0));
        // the empty marker never matches
        stimulus.push_back(make_cmd(pcma_pkg::CMD_ALLOCATE, pcma_pkg::EMPTY_PIN, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_LOOKUP, pcma_pkg::EMPTY_PIN, 3'd6));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_RELEASE, pcma_pkg::EMPTY_PIN, 3'd0));
        stimulus.push_back(make_cmd(CMD_UNUSED, 8'd0, 3'd0));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_RELEASE, 8'd254, 3'd5));
        stimulus.push_back(make_cmd(pcma_pkg::CMD_LOOKUP, 8'd254, 3'd6));

        // random part, alternating between filling and draining phases
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 300 == 0)
                for (int i = 2; i < POOL_SIZE; i++)
                    pin_pool[i] = pcma_pkg::PIN_W'($urandom_range(0, 254));
            stimulus.push_back(random_cmd((k / 150) % 2 == 1));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        burst_left = 0;
        foreach (stimulus[n])
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 40);
            end
            drive_command(stimulus[n]);
            burst_left--;
        end
        @(negedge clk);
        cmd_bus.valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("[pin_channel_map_allocator] OK");
        else
            $display("[pin_channel_map_allocator] ERROR");
        $finish;
    end

endmodule
